// File: design/bgsg_pkg.sv
// ---------------------------------------------------------------------------
// bgsg_pkg: shared types and constants of the burst gated sine generator
// Register indexes, burst modes, sample kinds, the queue item, the config
// bundles and the quarter-wave sine table entry function.
// ---------------------------------------------------------------------------
`default_nettype none

package bgsg_pkg;

   localparam int TABLE_BITS_DEF = 10;
   localparam logic [31:0] START_PHASE_DEF = 32'd0;
   localparam int QUEUE_DEPTH = 4;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register indexes on the config port
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_AMPLITUDE    = 4'd0,
      REG_DC_OFFSET    = 4'd1,
      REG_PHASE_STEP   = 4'd2,
      REG_START_DELAY  = 4'd3,
      REG_BURST_MODE   = 4'd4,
      REG_BURST_LENGTH = 4'd5,
      REG_BURST_PERIOD = 4'd6,
      REG_BURST_DELAY  = 4'd7
   } reg_index_type;

   localparam logic [1:0] MODE_CONTINUOUS = 2'd0;
   localparam logic [1:0] MODE_SINGLE     = 2'd1;
   localparam logic [1:0] MODE_REPEAT     = 2'd2;

   typedef enum logic [1:0] {
      KIND_ZERO   = 2'd0,
      KIND_OFFSET = 2'd1,
      KIND_SINE   = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] phase;
   } item_type;

   typedef struct packed {
      logic        full;
      logic        not_empty;
   } qstat_type;

   typedef struct packed {
      logic [31:0] phase_step;
      logic [31:0] start_delay;
      logic [1:0]  burst_mode;
      logic [31:0] burst_length;
      logic [31:0] burst_period;
      logic [31:0] burst_delay;
   } timing_type;

   typedef struct packed {
      logic [15:0]        amplitude;
      logic signed [15:0] dc_offset;
   } level_type;

   // Entry i of the quarter-wave table: 32767*sin(pi*(2i+1)/2^(tbits+2)),
   // Taylor series to x^15 in Q30. Evaluated at elaboration only.
   function automatic logic [14:0] sine_entry(input int unsigned i,
                                              input int unsigned tbits);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        v;
      x = (64'd3373259426 * (64'(i) * 64'd2 + 64'd1)) >> (tbits + 2);
      x2 = (x * x) >> 30;
      term = x;
      sum = $signed(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd210;
      sum = sum - $signed(term);
      if (sum < 0) begin
         sum = 64'sd0;
      end
      v = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[14:0];
   endfunction

endpackage

`default_nettype wire

// File: design/bgsg_front.sv
// ---------------------------------------------------------------------------
// bgsg_front: sample timing front end
// Keeps sample, window and phase counters, classifies each accepted tick as
// zero, offset or sine and pushes the kind with its phase into the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module bgsg_front #(
   parameter logic [31:0] START_PHASE = bgsg_pkg::START_PHASE_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_restart,
   input  wire bgsg_pkg::timing_type  timing,
   input  wire bgsg_pkg::qstat_type   qstat,
   output logic                       push,
   output bgsg_pkg::item_type         push_item
);
   import bgsg_pkg::*;

   logic [31:0] sample_count_ff, sample_count_in;
   logic [31:0] window_count_ff, window_count_in;
   logic [31:0] phase_acc_ff, phase_acc_in;

   logic [31:0] t, w, pacc, ph;
   logic [31:0] start_step, acc_step;
   logic [32:0] e_full, d1_full, d2_full, nw;
   logic        started, sine, offset_only, k_zero;

   assign req_stall = qstat.full;
   assign push = req_valid && !qstat.full;

   always_comb begin
      t = req_restart ? 32'd0 : sample_count_ff;
      w = req_restart ? 32'd0 : window_count_ff;
      pacc = req_restart ? START_PHASE : phase_acc_ff;

      // both next-phase candidates in parallel with the classification
      start_step = START_PHASE + timing.phase_step;
      acc_step = pacc + timing.phase_step;

      e_full = {1'b0, t} - {1'b0, timing.start_delay};
      started = !e_full[32];
      d1_full = {1'b0, e_full[31:0]} - {1'b0, timing.burst_delay};
      d2_full = {1'b0, w} - {1'b0, timing.burst_delay};

      sine = 1'b0;
      offset_only = 1'b0;
      k_zero = 1'b0;
      if (started) begin
         case (timing.burst_mode)
            MODE_CONTINUOUS: begin
               sine = 1'b1;
               k_zero = (e_full[31:0] == 32'd0);
            end
            MODE_SINGLE: begin
               if (d1_full[32]) begin
                  offset_only = 1'b1;
               end else if (d1_full[31:0] < timing.burst_length) begin
                  sine = 1'b1;
                  k_zero = (d1_full[31:0] == 32'd0);
               end
            end
            MODE_REPEAT: begin
               if (!d2_full[32] && (d2_full[31:0] < timing.burst_length)) begin
                  sine = 1'b1;
                  k_zero = (d2_full[31:0] == 32'd0);
               end else begin
                  offset_only = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      ph = k_zero ? START_PHASE : pacc;

      nw = {1'b0, w} + 33'd1;
      window_count_in = w;
      if (started) begin
         window_count_in = (nw >= {1'b0, timing.burst_period}) ? 32'd0 : nw[31:0];
      end
      phase_acc_in = sine ? (k_zero ? start_step : acc_step) : pacc;
      sample_count_in = (t == 32'hFFFF_FFFF) ? t : (t + 32'd1);

      push_item.phase = ph;
      if (sine) begin
         push_item.kind = KIND_SINE;
      end else if (offset_only) begin
         push_item.kind = KIND_OFFSET;
      end else begin
         push_item.kind = KIND_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= 32'd0;
         window_count_ff <= 32'd0;
         phase_acc_ff <= START_PHASE;
      end else if (push) begin
         sample_count_ff <= sample_count_in;
         window_count_ff <= window_count_in;
         phase_acc_ff <= phase_acc_in;
      end
   end

endmodule

`default_nettype wire

// File: design/bgsg_queue.sv
// ---------------------------------------------------------------------------
// bgsg_queue: short item queue between front and back
// Register-based FIFO; push and pop may happen in the same cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module bgsg_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire bgsg_pkg::item_type  push_item,
   input  wire logic                pop,
   output bgsg_pkg::item_type       pop_item,
   output bgsg_pkg::qstat_type      qstat
);
   import bgsg_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   item_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;

   assign pop_item = entry_ff[rd_ptr_ff];
   assign qstat.full = (count_ff == FULL_CNT);
   assign qstat.not_empty = (count_ff != '0);

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: design/bgsg_back.sv
// ---------------------------------------------------------------------------
// bgsg_back: sample synthesis back end
// Three stages: quarter-wave table lookup, amplitude multiply, then
// rounding, sign, offset add and 16-bit saturation into the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module bgsg_back #(
   parameter int TABLE_BITS = bgsg_pkg::TABLE_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire bgsg_pkg::qstat_type qstat,
   input  wire bgsg_pkg::item_type  pop_item,
   output logic                     pop,
   input  wire bgsg_pkg::level_type level,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic signed [15:0]       rsp_sample,
   output logic                     rsp_burst_active
);
   import bgsg_pkg::*;

   localparam int TAB_N = 1 << TABLE_BITS;

   logic [14:0] sine_tab [TAB_N];

   for (genvar g = 0; g < TAB_N; g++) begin : g_tab
      localparam logic [14:0] ENTRY = sine_entry(g, TABLE_BITS);
      assign sine_tab[g] = ENTRY;
   end

   logic                  adv;
   logic [TABLE_BITS-1:0] idx;

   // stage 1
   logic        s1_valid_ff;
   kind_type    s1_kind_ff;
   logic        s1_neg_ff;
   logic [14:0] s1_mag_ff;
   // stage 2
   logic        s2_valid_ff;
   kind_type    s2_kind_ff;
   logic        s2_neg_ff;
   logic [30:0] s2_prod_ff;
   // output
   logic               rsp_valid_ff;
   logic signed [15:0] rsp_sample_ff, rsp_sample_in;
   logic               rsp_burst_active_ff;

   logic [31:0]        rounded;
   logic signed [17:0] mag_s, sum_s;

   assign adv = !(rsp_valid_ff && rsp_stall);
   assign pop = adv && qstat.not_empty;

   assign idx = pop_item.phase[30] ? ~pop_item.phase[29 -: TABLE_BITS]
                                   : pop_item.phase[29 -: TABLE_BITS];

   always_comb begin
      rounded = {1'b0, s2_prod_ff} + 32'd16384;
      mag_s = $signed({2'b00, rounded[30:15]});
      if (s2_neg_ff) begin
         mag_s = -mag_s;
      end
      sum_s = mag_s + 18'(level.dc_offset);
      case (s2_kind_ff)
         KIND_SINE: begin
            if (sum_s > 18'sd32767) begin
               rsp_sample_in = 16'sh7FFF;
            end else if (sum_s < -18'sd32768) begin
               rsp_sample_in = -16'sh8000;
            end else begin
               rsp_sample_in = sum_s[15:0];
            end
         end
         KIND_OFFSET: rsp_sample_in = level.dc_offset;
         default:     rsp_sample_in = 16'sd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= pop;
         s2_valid_ff <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_kind_ff <= pop_item.kind;
         s1_neg_ff <= pop_item.phase[31];
         s1_mag_ff <= sine_tab[idx];
         s2_kind_ff <= s1_kind_ff;
         s2_neg_ff <= s1_neg_ff;
         s2_prod_ff <= level.amplitude * s1_mag_ff;
         rsp_sample_ff <= rsp_sample_in;
         rsp_burst_active_ff <= (s2_kind_ff == KIND_SINE);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_burst_active = rsp_burst_active_ff;

endmodule

`default_nettype wire

// File: design/burst_gated_sine_generator_top.sv
// ---------------------------------------------------------------------------
// burst_gated_sine_generator_top: DDS sine source with burst gating
// One request transaction is one sample tick; it yields one response
// transaction carrying the signed 16-bit sample and a burst-active flag.
//
// Usage:
//  - csr_we/csr_index/csr_wdata write the eight setup registers (amplitude,
//    dc offset, phase step, start delay, burst mode, length, period, delay).
//    Write only while no transaction is in flight. Indexes above 7 are
//    ignored.
//  - req_valid/req_stall/req_restart: a tick is taken at a clock edge with
//    req_valid high and req_stall low. req_restart clears time and phase
//    before that tick is computed.
//  - rsp_valid/rsp_stall/rsp_sample/rsp_burst_active: the sample is taken
//    when rsp_valid is high and rsp_stall is low.
// Pipeline: an accepted tick passes through the queue, then the table, multiply
//  and saturate stages; one sample per clock unless rsp_stall holds a valid response.
// Reset: synchronous, active high; counters clear, phase loads the start
//  phase, registers take their defaults, the queue and pipeline empty.
// Stall: while rsp_stall holds a valid response the back end freezes; the
//  4-entry queue keeps absorbing ticks, then req_stall rises.
// ---------------------------------------------------------------------------
`default_nettype none

module burst_gated_sine_generator_top #(
   parameter int          TABLE_BITS  = bgsg_pkg::TABLE_BITS_DEF,
   parameter logic [31:0] START_PHASE = bgsg_pkg::START_PHASE_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // config port
   input  wire logic                             csr_we,
   input  wire logic [bgsg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bgsg_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // request channel
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_restart,
   // response channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic signed [15:0]                    rsp_sample,
   output logic                                  rsp_burst_active
);
   import bgsg_pkg::*;

   // Setup registers
   timing_type timing_ff;
   level_type  level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff.amplitude <= 16'd32768;
         level_ff.dc_offset <= 16'sd0;
         timing_ff.phase_step <= 32'd0;
         timing_ff.start_delay <= 32'd0;
         timing_ff.burst_mode <= MODE_CONTINUOUS;
         timing_ff.burst_length <= 32'd1;
         timing_ff.burst_period <= 32'd2;
         timing_ff.burst_delay <= 32'd0;
      end else if (csr_we) begin
         case (csr_index)
            REG_AMPLITUDE:    level_ff.amplitude <= csr_wdata[15:0];
            REG_DC_OFFSET:    level_ff.dc_offset <= csr_wdata[15:0];
            REG_PHASE_STEP:   timing_ff.phase_step <= csr_wdata;
            REG_START_DELAY:  timing_ff.start_delay <= csr_wdata;
            REG_BURST_MODE:   timing_ff.burst_mode <= csr_wdata[1:0];
            REG_BURST_LENGTH: timing_ff.burst_length <= csr_wdata;
            REG_BURST_PERIOD: timing_ff.burst_period <= csr_wdata;
            REG_BURST_DELAY:  timing_ff.burst_delay <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Front: counters and classification
   qstat_type qstat;
   logic      push, pop;
   item_type  push_item, pop_item;

   bgsg_front #(
      .START_PHASE(START_PHASE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_restart(req_restart),
      .timing     (timing_ff),
      .qstat      (qstat),
      .push       (push),
      .push_item  (push_item)
   );

   // Queue decouples front from back-end stalls
   bgsg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_item(push_item),
      .pop      (pop),
      .pop_item (pop_item),
      .qstat    (qstat)
   );

   // Back: table, multiply, offset and saturate
   bgsg_back #(
      .TABLE_BITS(TABLE_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .qstat           (qstat),
      .pop_item        (pop_item),
      .pop             (pop),
      .level           (level_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample      (rsp_sample),
      .rsp_burst_active(rsp_burst_active)
   );

endmodule

`default_nettype wire

// File: design/bgsg_checker.sv
// ---------------------------------------------------------------------------
// bgsg_checker: port-level checks of the burst gated sine generator
// Watches the top-level ports only; attached by bind.
// ---------------------------------------------------------------------------
`default_nettype none

module bgsg_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [15:0] rsp_sample,
   input wire logic        rsp_burst_active
);

   // Nothing comes out the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // The queue can only fill while the response side was held
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> $past(rsp_valid && rsp_stall))
      else $error("request stalled without a held response");

   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response valid dropped while stalled");

   a_data_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_sample) && $stable(rsp_burst_active))
      else $error("response payload changed while stalled");

endmodule

bind burst_gated_sine_generator_top bgsg_checker u_bgsg_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_sample      (rsp_sample),
   .rsp_burst_active(rsp_burst_active)
);

`default_nettype wire
